### src/gfac_pkg.sv
// Shared types, constants and the 2^x table for the gain factor mapper.
`default_nettype none

package gfac_pkg;

  localparam int EXP_TABLE_ENTRIES = 64;
  localparam int JW = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int QW = 16 + JW;
  localparam int NW = 7;

  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic signed [23:0] DB_TO_EXP_Q24 = 24'sd2786635;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_MIN_FACTOR = 3'd1,
    REG_MAX_FACTOR = 3'd2,
    REG_MIN_DB     = 3'd3,
    REG_MAX_DB     = 3'd4
  } reg_idx_t;

  typedef enum logic {
    MODE_LINEAR = 1'b0,
    MODE_LOG    = 1'b1
  } gain_mode_t;

  typedef struct packed {
    gain_mode_t         mode;
    logic [23:0]        min_factor;
    logic [23:0]        max_factor;
    logic signed [15:0] min_db;
    logic signed [15:0] max_db;
  } cfg_t;

  typedef struct packed {
    logic [23:0] v;
    logic        last;
  } interp_t;

  typedef struct packed {
    logic [23:0]          lin;
    logic [31:0]          m;
    logic signed [NW-1:0] n;
    logic                 last;
  } expo_t;

  function automatic logic [63:0] taylor_step(input logic [63:0] term,
                                              input logic [63:0] y);
    return (term * y + (64'd1 << 29)) >> 30;
  endfunction

  // Q30 value of 2^(idx/N), built at elaboration.
  function automatic logic [31:0] exp_tab_entry(input int unsigned idx);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y = (64'(idx) * LN2_Q30 + 64'(EXP_TABLE_ENTRIES / 2)) / 64'(EXP_TABLE_ENTRIES);
    term = 64'd1 << 30;
    sum = term;
    term = taylor_step(term, y) / 64'd1;  sum = sum + term;
    term = taylor_step(term, y) / 64'd2;  sum = sum + term;
    term = taylor_step(term, y) / 64'd3;  sum = sum + term;
    term = taylor_step(term, y) / 64'd4;  sum = sum + term;
    term = taylor_step(term, y) / 64'd5;  sum = sum + term;
    term = taylor_step(term, y) / 64'd6;  sum = sum + term;
    term = taylor_step(term, y) / 64'd7;  sum = sum + term;
    term = taylor_step(term, y) / 64'd8;  sum = sum + term;
    term = taylor_step(term, y) / 64'd9;  sum = sum + term;
    term = taylor_step(term, y) / 64'd10; sum = sum + term;
    term = taylor_step(term, y) / 64'd11; sum = sum + term;
    term = taylor_step(term, y) / 64'd12; sum = sum + term;
    term = taylor_step(term, y) / 64'd13; sum = sum + term;
    term = taylor_step(term, y) / 64'd14; sum = sum + term;
    term = taylor_step(term, y) / 64'd15; sum = sum + term;
    term = taylor_step(term, y) / 64'd16; sum = sum + term;
    term = taylor_step(term, y) / 64'd17; sum = sum + term;
    term = taylor_step(term, y) / 64'd18; sum = sum + term;
    term = taylor_step(term, y) / 64'd19; sum = sum + term;
    term = taylor_step(term, y) / 64'd20; sum = sum + term;
    term = taylor_step(term, y) / 64'd21; sum = sum + term;
    if (idx == 0) begin
      sum = 64'd1 << 30;
    end else if (idx == EXP_TABLE_ENTRIES) begin
      sum = 64'd1 << 31;
    end
    return sum[31:0];
  endfunction

endpackage

`default_nettype wire

### src/gfac_regs.sv
// APB configuration registers for the gain factor mapper.
`default_nettype none

module gfac_regs
  import gfac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  output      cfg_t        cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_LINEAR;
      cfg.min_factor <= 24'd0;
      cfg.max_factor <= 24'd1048576;
      cfg.min_db     <= -16'sd24576;
      cfg.max_db     <= 16'sd0;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:       cfg.mode       <= gain_mode_t'(pwdata[0]);
        REG_MIN_FACTOR: cfg.min_factor <= pwdata[23:0];
        REG_MAX_FACTOR: cfg.max_factor <= pwdata[23:0];
        REG_MIN_DB:     cfg.min_db     <= $signed(pwdata[15:0]);
        REG_MAX_DB:     cfg.max_db     <= $signed(pwdata[15:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:       prdata = {31'd0, cfg.mode};
      REG_MIN_FACTOR: prdata = {8'd0, cfg.min_factor};
      REG_MAX_FACTOR: prdata = {8'd0, cfg.max_factor};
      REG_MIN_DB:     prdata = 32'(cfg.min_db);
      REG_MAX_DB:     prdata = 32'(cfg.max_db);
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### src/gfac_interp.sv
// Clamp, position and linear interpolation of factor or dB value (3 stages).
`default_nettype none

module gfac_interp
  import gfac_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [17:0] sample,
  input  wire logic               last,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      interp_t            out_data
);

  logic [2:0] vld;
  logic [2:0] en;

  logic signed [17:0] s_cl;
  logic [15:0]        db_a;
  logic [15:0]        db_b;

  logic [16:0]        p1;
  logic signed [24:0] diff1;
  logic [23:0]        base1;
  logic               last1;

  logic signed [42:0] prod2;
  logic [23:0]        base2;
  logic               last2;

  logic signed [43:0] acc;
  logic [23:0]        v3;
  logic               last3;

  always_comb begin
    en[2] = !vld[2] || out_ready;
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[2];
  assign out_data  = '{v: v3, last: last3};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 3'b000;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  // offset binary dB values
  assign db_a = {~cfg.min_db[15], cfg.min_db[14:0]};
  assign db_b = {~cfg.max_db[15], cfg.max_db[14:0]};

  always_comb begin
    if (sample > 18'sd32768) begin
      s_cl = 18'sd32768;
    end else if (sample < -18'sd32768) begin
      s_cl = -18'sd32768;
    end else begin
      s_cl = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1    <= 17'(s_cl + 18'sd32768);
      last1 <= last;
      if (cfg.mode == MODE_LOG) begin
        base1 <= {8'd0, db_a};
        diff1 <= $signed({9'd0, db_b}) - $signed({9'd0, db_a});
      end else begin
        base1 <= cfg.min_factor;
        diff1 <= $signed({1'b0, cfg.max_factor}) - $signed({1'b0, cfg.min_factor});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod2 <= diff1 * $signed({1'b0, p1});
      base2 <= base1;
      last2 <= last1;
    end
  end

  assign acc = $signed({4'd0, base2, 16'd0}) + 44'(prod2) + 44'sd32768;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      v3    <= acc[39:16];
      last3 <= last2;
    end
  end

endmodule

`default_nettype wire

### src/gfac_exp.sv
// dB to base-2 exponent and interpolated 2^x mantissa lookup (5 stages).
`default_nettype none

module gfac_exp
  import gfac_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output      logic    in_ready,
  input  wire interp_t in_data,
  output      logic    out_valid,
  input  wire logic    out_ready,
  output      expo_t   out_data
);

  logic [4:0] vld;
  logic [4:0] en;

  logic [31:0] tab [0:EXP_TABLE_ENTRIES];

  for (genvar g = 0; g <= EXP_TABLE_ENTRIES; g++) begin : g_tab
    assign tab[g] = exp_tab_entry(g);
  end

  logic signed [15:0] db;

  logic signed [39:0] prod1;
  logic [23:0]        lin1;
  logic               last1;

  logic signed [40:0] xs;
  logic [QW-1:0]      q;
  logic [JW-1:0]      j_raw;
  logic [JW-1:0]      j2;
  logic [15:0]        r2;
  logic signed [NW-1:0] n2;
  logic [23:0]        lin2;
  logic               last2;

  logic [31:0]        tj3;
  logic [31:0]        dt3;
  logic [15:0]        r3;
  logic signed [NW-1:0] n3;
  logic [23:0]        lin3;
  logic               last3;

  logic [47:0]        prod4;
  logic [31:0]        tj4;
  logic signed [NW-1:0] n4;
  logic [23:0]        lin4;
  logic               last4;

  logic [31:0]        m5;
  logic signed [NW-1:0] n5;
  logic [23:0]        lin5;
  logic               last5;

  always_comb begin
    en[4] = !vld[4] || out_ready;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[4];
  assign out_data  = '{lin: lin5, m: m5, n: n5, last: last5};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 5'd0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign db = $signed({~in_data.v[15], in_data.v[14:0]});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod1 <= db * DB_TO_EXP_Q24;
      lin1  <= in_data.v;
      last1 <= in_data.last;
    end
  end

  // Q16 exponent, integer part n and fraction index into the table
  assign xs    = (41'(prod1) + 41'sd32768) >>> 16;
  assign q     = QW'(xs[15:0]) * QW'(EXP_TABLE_ENTRIES);
  assign j_raw = q[QW-1:16];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      j2    <= (j_raw >= JW'(EXP_TABLE_ENTRIES)) ? JW'(EXP_TABLE_ENTRIES - 1) : j_raw;
      r2    <= q[15:0];
      n2    <= xs[NW+15:16];
      lin2  <= lin1;
      last2 <= last1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tj3   <= tab[j2];
      dt3   <= tab[j2 + JW'(1)] - tab[j2];
      r3    <= r2;
      n3    <= n2;
      lin3  <= lin2;
      last3 <= last2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      prod4 <= 48'(dt3) * 48'(r3);
      tj4   <= tj3;
      n4    <= n3;
      lin4  <= lin3;
      last4 <= last3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      m5    <= tj4 + 32'((prod4 + 48'd32768) >> 16);
      n5    <= n4;
      lin5  <= lin4;
      last5 <= last4;
    end
  end

endmodule

`default_nettype wire

### src/gfac_shift.sv
// Final scaling, saturation and mode select into the output register.
`default_nettype none

module gfac_shift
  import gfac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire expo_t       in_data,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [23:0] gain,
  output      logic        sat,
  output      logic        last
);

  logic signed [7:0] sh;
  logic [40:0]       half;
  logic [40:0]       t;
  logic [23:0]       gain_next;
  logic              sat_next;

  assign in_ready = !out_valid || out_ready;
  assign sh       = 8'sd10 - 8'(in_data.n);
  assign half     = 41'd1 << (sh[6:0] - 7'd1);
  assign t        = (41'(in_data.m) + half) >> sh[6:0];

  always_comb begin
    gain_next = 24'd0;
    sat_next  = 1'b0;
    if (cfg.mode == MODE_LINEAR) begin
      gain_next = in_data.lin;
    end else if (in_data.n >= NW'(4)) begin
      sat_next = 1'b1;
    end else if (sh > 8'sd40) begin
      gain_next = 24'd0;
    end else if (t > 41'hFFFFFF) begin
      sat_next = 1'b1;
    end else begin
      gain_next = t[23:0];
    end
    if (sat_next) gain_next = 24'hFFFFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      gain <= gain_next;
      sat  <= sat_next;
      last <= in_data.last;
    end
  end

endmodule

`default_nettype wire

### src/sample_to_gain_factor.sv
// Top level of the control sample to gain factor mapper.
// Maps a Q3.15 control sample, clamped to +-1, to an unsigned Q4.20 gain: linear
// interpolation between two factors, or a dB interpolation followed by 10^(dB/20)
// from an interpolated 2^x table. One transfer is taken every cycle unless m_tready
// holds the output; the path is 3 interpolation stages, 5 exponent/table stages
// and 1 output register. Each stage stalls only when it holds data, so bubbles
// close up under backpressure. No startup sweep.
`default_nettype none

module sample_to_gain_factor
  import gfac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,   // [17:0] control_sample, [23:18] zero
  input  wire logic        s_tlast,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [23:0] m_tdata,   // [23:0] gain_factor
  output      logic        m_tuser,   // [0] saturated
  output      logic        m_tlast
);

  cfg_t    cfg;
  interp_t ip_data;
  expo_t   ex_data;
  logic    ip_valid;
  logic    ip_ready;
  logic    ex_valid;
  logic    ex_ready;

  gfac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gfac_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    ($signed(s_tdata[17:0])),
    .last      (s_tlast),
    .out_valid (ip_valid),
    .out_ready (ip_ready),
    .out_data  (ip_data)
  );

  gfac_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ip_valid),
    .in_ready  (ip_ready),
    .in_data   (ip_data),
    .out_valid (ex_valid),
    .out_ready (ex_ready),
    .out_data  (ex_data)
  );

  gfac_shift u_shift (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (ex_valid),
    .in_ready  (ex_ready),
    .in_data   (ex_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .gain      (m_tdata),
    .sat       (m_tuser),
    .last      (m_tlast)
  );

endmodule

`default_nettype wire
